FILE: rtl/core/vna_pkg.sv
`default_nettype none

package vna_pkg;

    localparam int unsigned IDX_W     = 10;
    localparam int unsigned IDX_LIMIT = 1024;
    localparam int unsigned POS_W     = 16;
    localparam int unsigned EDGE_W    = 17;
    localparam int unsigned PROD_W    = 34;
    localparam int unsigned CROSS_W   = 35;
    localparam int unsigned SUM_W     = 44;
    localparam int unsigned SCL_W     = 20;
    localparam int unsigned SQ_W      = 42;
    localparam int unsigned LEN_W     = 21;
    localparam int unsigned Q_W       = 15;
    localparam int unsigned NUM_W     = 37;
    localparam int unsigned OUT_W     = 16;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_TRI   = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_TRI,
        OP_READ,
        OP_ZERO
    } op_kind_t;

    typedef struct packed {
        op_kind_t                 kind;
        logic [IDX_W-1:0]         a;
        logic [IDX_W-1:0]         b;
        logic [IDX_W-1:0]         c;
        logic signed [POS_W-1:0]  px;
        logic signed [POS_W-1:0]  py;
        logic signed [POS_W-1:0]  pz;
    } op_t;

    typedef struct packed {
        logic signed [OUT_W-1:0]  nx;
        logic signed [OUT_W-1:0]  ny;
        logic signed [OUT_W-1:0]  nz;
        logic                     zero;
    } result_t;

    typedef enum logic [3:0] {
        B_CLEAR,
        B_IDLE,
        B_PA,
        B_PB,
        B_PC,
        B_PE,
        B_MUL,
        B_ACC_RD,
        B_ACC_WR,
        B_SUM_RD,
        B_NORM_GO,
        B_NORM_WAIT,
        B_OUT
    } back_state_t;

    typedef enum logic [2:0] {
        N_IDLE,
        N_SHIFT,
        N_SQ,
        N_SQRT,
        N_DINIT,
        N_DIV,
        N_DONE
    } norm_state_t;

endpackage

`default_nettype wire

FILE: rtl/core/vertex_normal_accumulator.sv
// a write stores the position and clears the sum; a triangle adds its cross product to
// the sums of its three corners; a read scales the sum (1 to 25 shift steps), takes the
// root (21 square-root steps) and divides in the shared normalize unit; a zero sum or an
// out-of-range read gives the zero flag; the back end takes one request at a time
// from a two-entry queue; reset: a clearing pass zeroes all min(VERTEX_COUNT, 1024)
// sum entries, requests stall until it is done; the position memory is not cleared
`default_nettype none

module vertex_normal_accumulator
    import vna_pkg::*;
#(
    parameter int unsigned VERTEX_COUNT = 1024
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     req_valid,
    output logic                          req_stall,
    input  wire logic [1:0]               req_type,
    input  wire logic [IDX_W-1:0]         vert_a,
    input  wire logic [IDX_W-1:0]         vert_b,
    input  wire logic [IDX_W-1:0]         vert_c,
    input  wire logic signed [POS_W-1:0]  pos_x,
    input  wire logic signed [POS_W-1:0]  pos_y,
    input  wire logic signed [POS_W-1:0]  pos_z,
    output logic                          rsp_valid,
    input  wire logic                     rsp_stall,
    output logic signed [OUT_W-1:0]       norm_x,
    output logic signed [OUT_W-1:0]       norm_y,
    output logic signed [OUT_W-1:0]       norm_z,
    output logic                          zero_normal
);

    logic    q_valid;
    op_t     q_item;
    logic    q_pop;
    logic    clearing;
    logic    slot_free;
    logic    res_valid;
    result_t res;
    logic    rsp_valid_reg;
    result_t rsp_reg;

    assign slot_free   = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid   = rsp_valid_reg;
    assign norm_x      = rsp_reg.nx;
    assign norm_y      = rsp_reg.ny;
    assign norm_z      = rsp_reg.nz;
    assign zero_normal = rsp_reg.zero;

    vna_front #(
        .VERTEX_COUNT (VERTEX_COUNT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_type  (req_type),
        .vert_a    (vert_a),
        .vert_b    (vert_b),
        .vert_c    (vert_c),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .clearing  (clearing),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    vna_back #(
        .VERTEX_COUNT (VERTEX_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .clearing  (clearing),
        .slot_free (slot_free),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            rsp_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

`ifndef SYNTHESIS
    // a result is only handed over when the output slot can take it
    assert property (@(posedge clk) disable iff (!rst_n) res_valid |-> slot_free)
        else $error("result produced while output slot is busy");

    // no request enters while the sum memory is being cleared
    assert property (@(posedge clk) disable iff (!rst_n) clearing |-> req_stall)
        else $error("request accepted during clearing pass");

    // the back end never pops an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("queue popped while empty");

    // a zero flag always comes with the zero vector
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && zero_normal) |-> (norm_x == '0 && norm_y == '0 && norm_z == '0))
        else $error("zero flag with nonzero normal");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/vna_front.sv
`default_nettype none

module vna_front
    import vna_pkg::*;
#(
    parameter int unsigned VERTEX_COUNT = 1024
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     req_valid,
    output logic                          req_stall,
    input  wire logic [1:0]               req_type,
    input  wire logic [IDX_W-1:0]         vert_a,
    input  wire logic [IDX_W-1:0]         vert_b,
    input  wire logic [IDX_W-1:0]         vert_c,
    input  wire logic signed [POS_W-1:0]  pos_x,
    input  wire logic signed [POS_W-1:0]  pos_y,
    input  wire logic signed [POS_W-1:0]  pos_z,
    input  wire logic                     clearing,
    output logic                          q_valid,
    output op_t                           q_item,
    input  wire logic                     q_pop
);

    op_t        slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       a_ok;
    logic       b_ok;
    logic       c_ok;
    logic       keep;
    logic       push;
    op_t        item;

    assign a_ok = 32'(vert_a) < VERTEX_COUNT;
    assign b_ok = 32'(vert_b) < VERTEX_COUNT;
    assign c_ok = 32'(vert_c) < VERTEX_COUNT;

    always_comb
    begin
        item.a    = vert_a;
        item.b    = vert_b;
        item.c    = vert_c;
        item.px   = pos_x;
        item.py   = pos_y;
        item.pz   = pos_z;
        item.kind = OP_ZERO;
        keep      = 1'b0;
        unique case (req_type)
            REQ_WRITE:
            begin
                item.kind = OP_WRITE;
                keep      = a_ok;
            end
            REQ_TRI:
            begin
                item.kind = OP_TRI;
                keep      = a_ok && b_ok && c_ok;
            end
            REQ_READ:
            begin
                item.kind = a_ok ? OP_READ : OP_ZERO;
                keep      = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign req_stall = (count_reg == 2'd2) || clearing;
    assign push      = req_valid && !req_stall && keep;
    assign q_valid   = count_reg != 2'd0;
    assign q_item    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/vna_norm.sv
`default_nettype none

module vna_norm
    import vna_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic signed [SUM_W-1:0]  sum_x,
    input  wire logic signed [SUM_W-1:0]  sum_y,
    input  wire logic signed [SUM_W-1:0]  sum_z,
    output logic                          done,
    output result_t                       result
);

    norm_state_t       state_reg;
    norm_state_t       state_next;
    logic [SUM_W-1:0]  mag_reg [3];
    logic              neg_reg [3];
    logic [1:0]        k_reg;
    logic [SQ_W-1:0]   v_reg;
    logic [SQ_W-1:0]   rt_reg;
    logic [SQ_W-1:0]   bit_reg;
    logic [NUM_W-1:0]  rem_reg;
    logic [NUM_W-1:0]  dsh_reg;
    logic [Q_W-1:0]    q_reg;
    logic [3:0]        cnt_reg;
    result_t           result_reg;

    logic [SUM_W-1:0]   ormag;
    logic               hi;
    logic               mid;
    logic               nonzero;
    logic [SCL_W-1:0]   scl;
    logic [2*SCL_W-1:0] sqp;
    logic [SQ_W-1:0]    trial;
    logic [LEN_W-1:0]   len;
    logic               ge;
    logic [Q_W-1:0]     qf;
    logic [OUT_W-1:0]   qs;

    assign ormag   = mag_reg[0] | mag_reg[1] | mag_reg[2];
    assign hi      = |ormag[SUM_W-1:SCL_W];
    assign mid     = ormag[SCL_W-1];
    assign nonzero = |ormag;
    assign scl     = mag_reg[k_reg][SCL_W-1:0];
    assign sqp     = scl * scl;
    assign trial   = rt_reg + bit_reg;
    assign len     = rt_reg[LEN_W-1:0];
    assign ge      = rem_reg >= dsh_reg;
    assign qf      = {q_reg[Q_W-2:0], ge};
    assign qs      = neg_reg[k_reg] ? (OUT_W'(0) - {1'b0, qf}) : {1'b0, qf};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    state_next = N_SHIFT;
                end
            end
            N_SHIFT:
            begin
                if (!nonzero)
                begin
                    state_next = N_DONE;
                end
                else if (!hi && mid)
                begin
                    state_next = N_SQ;
                end
            end
            N_SQ:
            begin
                if (k_reg == 2'd2)
                begin
                    state_next = N_SQRT;
                end
            end
            N_SQRT:
            begin
                if (bit_reg[0])
                begin
                    state_next = N_DINIT;
                end
            end
            N_DINIT:
            begin
                state_next = N_DIV;
            end
            N_DIV:
            begin
                if (cnt_reg == 4'(Q_W - 1))
                begin
                    state_next = (k_reg == 2'd2) ? N_DONE : N_DINIT;
                end
            end
            N_DONE:
            begin
                state_next = N_IDLE;
            end
            default:
            begin
                state_next = N_IDLE;
            end
        endcase
    end

    always_comb
    begin
        done = state_reg == N_DONE;
    end

    assign result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            k_reg     <= 2'd0;
            cnt_reg   <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                N_SHIFT:
                begin
                    k_reg <= 2'd0;
                end
                N_SQ:
                begin
                    k_reg <= (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
                end
                N_DINIT:
                begin
                    cnt_reg <= 4'd0;
                end
                N_DIV:
                begin
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'(Q_W - 1))
                    begin
                        k_reg <= k_reg + 2'd1;
                    end
                end
                default:
                begin
                    k_reg <= k_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    mag_reg[0] <= sum_x[SUM_W-1] ? SUM_W'(0) - sum_x : sum_x;
                    mag_reg[1] <= sum_y[SUM_W-1] ? SUM_W'(0) - sum_y : sum_y;
                    mag_reg[2] <= sum_z[SUM_W-1] ? SUM_W'(0) - sum_z : sum_z;
                    neg_reg[0] <= sum_x[SUM_W-1];
                    neg_reg[1] <= sum_y[SUM_W-1];
                    neg_reg[2] <= sum_z[SUM_W-1];
                end
            end
            N_SHIFT:
            begin
                v_reg <= '0;
                if (!nonzero)
                begin
                    result_reg <= '{nx: '0, ny: '0, nz: '0, zero: 1'b1};
                end
                else if (hi)
                begin
                    mag_reg[0] <= mag_reg[0] >> 1;
                    mag_reg[1] <= mag_reg[1] >> 1;
                    mag_reg[2] <= mag_reg[2] >> 1;
                end
                else if (!mid)
                begin
                    mag_reg[0] <= mag_reg[0] << 1;
                    mag_reg[1] <= mag_reg[1] << 1;
                    mag_reg[2] <= mag_reg[2] << 1;
                end
            end
            N_SQ:
            begin
                v_reg          <= v_reg + SQ_W'(sqp);
                rt_reg         <= '0;
                bit_reg        <= SQ_W'(1) << (SQ_W - 2);
                result_reg.zero <= 1'b0;
            end
            N_SQRT:
            begin
                if (v_reg >= trial)
                begin
                    v_reg  <= v_reg - trial;
                    rt_reg <= (rt_reg >> 1) + bit_reg;
                end
                else
                begin
                    rt_reg <= rt_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            N_DINIT:
            begin
                rem_reg <= NUM_W'({scl, Q_W'(0)}) + NUM_W'(len);
                dsh_reg <= NUM_W'({len, 1'b0}) << (Q_W - 1);
                q_reg   <= '0;
            end
            N_DIV:
            begin
                if (ge)
                begin
                    rem_reg <= rem_reg - dsh_reg;
                end
                q_reg   <= qf;
                dsh_reg <= dsh_reg >> 1;
                if (cnt_reg == 4'(Q_W - 1))
                begin
                    case (k_reg)
                        2'd0:    result_reg.nx <= qs;
                        2'd1:    result_reg.ny <= qs;
                        default: result_reg.nz <= qs;
                    endcase
                end
            end
            default:
            begin
                q_reg <= q_reg;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/vna_back.sv
`default_nettype none

module vna_back
    import vna_pkg::*;
#(
    parameter int unsigned VERTEX_COUNT = 1024
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  q_valid,
    input  wire op_t   q_item,
    output logic       q_pop,
    output logic       clearing,
    input  wire logic  slot_free,
    output logic       res_valid,
    output result_t    res
);

    localparam int unsigned DEPTH = (VERTEX_COUNT > IDX_LIMIT) ? IDX_LIMIT : VERTEX_COUNT;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned PW    = 3 * POS_W;
    localparam int unsigned SW    = 3 * SUM_W;
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    logic [PW-1:0] pos_mem [DEPTH];
    logic [SW-1:0] sum_mem [DEPTH];
    logic [PW-1:0] pos_rd_reg;
    logic [SW-1:0] sum_rd_reg;

    back_state_t state_reg;
    back_state_t state_next;
    logic [AW-1:0] clr_reg;
    logic [2:0]    step_reg;
    logic [1:0]    vsel_reg;
    op_t           cur_reg;
    result_t       res_reg;

    logic signed [POS_W-1:0]   pax_reg, pay_reg, paz_reg;
    logic signed [EDGE_W-1:0]  e1x_reg, e1y_reg, e1z_reg;
    logic signed [EDGE_W-1:0]  e2x_reg, e2y_reg, e2z_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [CROSS_W-1:0] nx_reg, ny_reg, nz_reg;

    logic          pos_we;
    logic          sum_we;
    logic [AW-1:0] pos_raddr;
    logic [AW-1:0] sum_raddr;
    logic [AW-1:0] sum_waddr;
    logic [SW-1:0] sum_wdata;
    logic          norm_start;
    logic          norm_done;
    result_t       norm_res;

    logic signed [POS_W-1:0]   rx, ry, rz;
    logic signed [SUM_W-1:0]   sx, sy, sz;
    logic signed [EDGE_W-1:0]  ma, mb;
    logic signed [PROD_W-1:0]  prod;
    logic signed [CROSS_W-1:0] prod_ext;
    logic [IDX_W-1:0]          vidx;

    function automatic logic [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0]   s,
        input logic signed [CROSS_W-1:0] n
    );
        logic signed [SUM_W:0] r;
        r = $signed({s[SUM_W-1], s}) + $signed({{(SUM_W+1-CROSS_W){n[CROSS_W-1]}}, n});
        if (r[SUM_W] != r[SUM_W-1])
        begin
            return r[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        return r[SUM_W-1:0];
    endfunction

    assign rx = pos_rd_reg[PW-1 -: POS_W];
    assign ry = pos_rd_reg[2*POS_W-1 -: POS_W];
    assign rz = pos_rd_reg[POS_W-1:0];
    assign sx = sum_rd_reg[SW-1 -: SUM_W];
    assign sy = sum_rd_reg[2*SUM_W-1 -: SUM_W];
    assign sz = sum_rd_reg[SUM_W-1:0];

    always_comb
    begin
        case (vsel_reg)
            2'd0:    vidx = cur_reg.a;
            2'd1:    vidx = cur_reg.b;
            default: vidx = cur_reg.c;
        endcase
    end

    always_comb
    begin
        case (step_reg)
            3'd0:
            begin
                ma = e1y_reg;
                mb = e2z_reg;
            end
            3'd1:
            begin
                ma = e1z_reg;
                mb = e2y_reg;
            end
            3'd2:
            begin
                ma = e1z_reg;
                mb = e2x_reg;
            end
            3'd3:
            begin
                ma = e1x_reg;
                mb = e2z_reg;
            end
            3'd4:
            begin
                ma = e1x_reg;
                mb = e2y_reg;
            end
            default:
            begin
                ma = e1y_reg;
                mb = e2x_reg;
            end
        endcase
    end

    assign prod     = ma * mb;
    assign prod_ext = {{(CROSS_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_CLEAR:
            begin
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_item.kind)
                        OP_WRITE: state_next = B_IDLE;
                        OP_TRI:   state_next = B_PA;
                        OP_READ:  state_next = B_SUM_RD;
                        OP_ZERO:  state_next = B_OUT;
                        default:  state_next = B_IDLE;
                    endcase
                end
            end
            B_PA:
            begin
                state_next = B_PB;
            end
            B_PB:
            begin
                state_next = B_PC;
            end
            B_PC:
            begin
                state_next = B_PE;
            end
            B_PE:
            begin
                state_next = B_MUL;
            end
            B_MUL:
            begin
                if (step_reg == 3'd6)
                begin
                    state_next = B_ACC_RD;
                end
            end
            B_ACC_RD:
            begin
                state_next = B_ACC_WR;
            end
            B_ACC_WR:
            begin
                state_next = (vsel_reg == 2'd2) ? B_IDLE : B_ACC_RD;
            end
            B_SUM_RD:
            begin
                state_next = B_NORM_GO;
            end
            B_NORM_GO:
            begin
                state_next = B_NORM_WAIT;
            end
            B_NORM_WAIT:
            begin
                if (norm_done)
                begin
                    state_next = B_OUT;
                end
            end
            B_OUT:
            begin
                if (slot_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pos_we     = 1'b0;
        sum_we     = 1'b0;
        q_pop      = 1'b0;
        norm_start = 1'b0;
        res_valid  = 1'b0;
        pos_raddr  = cur_reg.a[AW-1:0];
        sum_raddr  = vidx[AW-1:0];
        sum_waddr  = vidx[AW-1:0];
        sum_wdata  = '0;
        unique case (state_reg)
            B_CLEAR:
            begin
                sum_we    = 1'b1;
                sum_waddr = clr_reg;
            end
            B_IDLE:
            begin
                q_pop = q_valid;
                if (q_valid && q_item.kind == OP_WRITE)
                begin
                    pos_we    = 1'b1;
                    sum_we    = 1'b1;
                    sum_waddr = q_item.a[AW-1:0];
                end
            end
            B_PB:
            begin
                pos_raddr = cur_reg.b[AW-1:0];
            end
            B_PC:
            begin
                pos_raddr = cur_reg.c[AW-1:0];
            end
            B_ACC_WR:
            begin
                sum_we    = 1'b1;
                sum_wdata = {sat_add(sx, nx_reg), sat_add(sy, ny_reg), sat_add(sz, nz_reg)};
            end
            B_SUM_RD:
            begin
                sum_raddr = cur_reg.a[AW-1:0];
            end
            B_NORM_GO:
            begin
                norm_start = 1'b1;
            end
            B_OUT:
            begin
                res_valid = slot_free;
            end
            default:
            begin
                pos_we = 1'b0;
            end
        endcase
    end

    assign clearing = state_reg == B_CLEAR;
    assign res      = res_reg;

    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            pos_mem[q_item.a[AW-1:0]] <= {q_item.px, q_item.py, q_item.pz};
        end
        pos_rd_reg <= pos_mem[pos_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (sum_we)
        begin
            sum_mem[sum_waddr] <= sum_wdata;
        end
        sum_rd_reg <= sum_mem[sum_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_CLEAR;
            clr_reg   <= '0;
            step_reg  <= 3'd0;
            vsel_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_CLEAR)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (state_reg == B_PE)
            begin
                step_reg <= 3'd0;
            end
            else if (state_reg == B_MUL)
            begin
                step_reg <= step_reg + 3'd1;
            end
            if (state_reg == B_MUL)
            begin
                vsel_reg <= 2'd0;
            end
            else if (state_reg == B_ACC_WR)
            begin
                vsel_reg <= vsel_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    cur_reg <= q_item;
                    res_reg <= '{nx: '0, ny: '0, nz: '0, zero: 1'b1};
                end
            end
            B_PB:
            begin
                pax_reg <= rx;
                pay_reg <= ry;
                paz_reg <= rz;
            end
            B_PC:
            begin
                e1x_reg <= $signed({rx[POS_W-1], rx}) - $signed({pax_reg[POS_W-1], pax_reg});
                e1y_reg <= $signed({ry[POS_W-1], ry}) - $signed({pay_reg[POS_W-1], pay_reg});
                e1z_reg <= $signed({rz[POS_W-1], rz}) - $signed({paz_reg[POS_W-1], paz_reg});
            end
            B_PE:
            begin
                e2x_reg <= $signed({rx[POS_W-1], rx}) - $signed({pax_reg[POS_W-1], pax_reg});
                e2y_reg <= $signed({ry[POS_W-1], ry}) - $signed({pay_reg[POS_W-1], pay_reg});
                e2z_reg <= $signed({rz[POS_W-1], rz}) - $signed({paz_reg[POS_W-1], paz_reg});
                nx_reg  <= '0;
                ny_reg  <= '0;
                nz_reg  <= '0;
            end
            B_MUL:
            begin
                prod_reg <= prod;
                case (step_reg)
                    3'd1:    nx_reg <= nx_reg + prod_ext;
                    3'd2:    nx_reg <= nx_reg - prod_ext;
                    3'd3:    ny_reg <= ny_reg + prod_ext;
                    3'd4:    ny_reg <= ny_reg - prod_ext;
                    3'd5:    nz_reg <= nz_reg + prod_ext;
                    3'd6:    nz_reg <= nz_reg - prod_ext;
                    default: nx_reg <= nx_reg;
                endcase
            end
            B_NORM_WAIT:
            begin
                if (norm_done)
                begin
                    res_reg <= norm_res;
                end
            end
            default:
            begin
                res_reg <= res_reg;
            end
        endcase
    end

    vna_norm u_norm (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (norm_start),
        .sum_x  (sx),
        .sum_y  (sy),
        .sum_z  (sz),
        .done   (norm_done),
        .result (norm_res)
    );

endmodule

`default_nettype wire

FILE: tb/sv/vertex_normal_accumulator_test.sv
`default_nettype none

module vertex_normal_accumulator_test;
    import vna_pkg::*;

    localparam int unsigned VCOUNT    = 1024;
    localparam logic [1:0]  REQ_SPARE = 2'd3;
    localparam int unsigned NORM_TOP  = 19;
    localparam longint      SUM_HI    = 64'sd8796093022207;
    localparam longint      SUM_LO    = -64'sd8796093022208;
    localparam longint      CYCLE_CAP = 64'd3000000;

    typedef struct packed {
        logic signed [OUT_W-1:0] nx;
        logic signed [OUT_W-1:0] ny;
        logic signed [OUT_W-1:0] nz;
        logic                    zero;
    } normal_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    req_valid = 1'b0;
    logic                    req_stall;
    logic [1:0]              req_type = REQ_WRITE;
    logic [IDX_W-1:0]        vert_a = '0;
    logic [IDX_W-1:0]        vert_b = '0;
    logic [IDX_W-1:0]        vert_c = '0;
    logic signed [POS_W-1:0] pos_x = '0;
    logic signed [POS_W-1:0] pos_y = '0;
    logic signed [POS_W-1:0] pos_z = '0;
    logic                    rsp_valid;
    logic                    rsp_stall = 1'b0;
    logic signed [OUT_W-1:0] norm_x;
    logic signed [OUT_W-1:0] norm_y;
    logic signed [OUT_W-1:0] norm_z;
    logic                    zero_normal;

    logic signed [POS_W-1:0] mesh_pos [VCOUNT][3];
    longint                  normal_sum [VCOUNT][3];
    bit                      placed [VCOUNT];
    normal_t                 pending_normals [$];
    int                      errors = 0;
    longint                  cycles = 0;
    bit                      lazy = 1'b1;
    int                      rsp_hold = 0;

    vertex_normal_accumulator #(.VERTEX_COUNT(VCOUNT)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
        .vert_a(vert_a), .vert_b(vert_b), .vert_c(vert_c),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
        .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z), .zero_normal(zero_normal)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic longint sat_add(longint s, longint n);
        longint r;
        r = s + n;
        if (r > SUM_HI)
            return SUM_HI;
        if (r < SUM_LO)
            return SUM_LO;
        return r;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic normal_t unit_normal(int i);
        normal_t         n;
        longint unsigned mg [3];
        longint unsigned m;
        longint unsigned sq;
        longint unsigned len;
        longint unsigned q;
        logic [15:0]     o [3];
        int              h;
        m = 0;
        sq = 0;
        h = 0;
        for (int k = 0; k < 3; k++)
        begin
            mg[k] = normal_sum[i][k] < 0 ? -normal_sum[i][k] : normal_sum[i][k];
            if (mg[k] > m)
                m = mg[k];
        end
        if (m == 0)
        begin
            n = '0;
            n.zero = 1'b1;
            return n;
        end
        while ((m >> h) > 1)
            h++;
        for (int k = 0; k < 3; k++)
        begin
            if (h > NORM_TOP)
                mg[k] = mg[k] >> (h - NORM_TOP);
            else
                mg[k] = mg[k] << (NORM_TOP - h);
            sq += mg[k] * mg[k];
        end
        len = int_sqrt(sq);
        for (int k = 0; k < 3; k++)
        begin
            q = (2 * mg[k] * 16384 + len) / (2 * len);
            o[k] = normal_sum[i][k] < 0 ? 16'(-q) : 16'(q);
        end
        n.nx = o[0];
        n.ny = o[1];
        n.nz = o[2];
        n.zero = 1'b0;
        return n;
    endfunction

    function automatic void predict(logic [1:0] t, int a, int b, int c,
                                    logic signed [15:0] x, logic signed [15:0] y,
                                    logic signed [15:0] z);
        longint e1 [3];
        longint e2 [3];
        longint cr [3];
        int     corner [3];
        case (t)
            REQ_WRITE:
            begin
                mesh_pos[a][0] = x;
                mesh_pos[a][1] = y;
                mesh_pos[a][2] = z;
                for (int k = 0; k < 3; k++)
                    normal_sum[a][k] = 0;
                placed[a] = 1'b1;
            end
            REQ_TRI:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    e1[k] = longint'(mesh_pos[b][k]) - longint'(mesh_pos[a][k]);
                    e2[k] = longint'(mesh_pos[c][k]) - longint'(mesh_pos[a][k]);
                end
                cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
                cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
                cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
                corner[0] = a;
                corner[1] = b;
                corner[2] = c;
                foreach (corner[j])
                    for (int k = 0; k < 3; k++)
                        normal_sum[corner[j]][k] = sat_add(normal_sum[corner[j]][k], cr[k]);
            end
            REQ_READ:
                pending_normals = {pending_normals, unit_normal(a)};
            default: ;
        endcase
    endfunction

    task automatic send_request(logic [1:0] t, int a, int b, int c,
                                logic signed [15:0] x, logic signed [15:0] y,
                                logic signed [15:0] z);
        int gap;
        gap = lazy ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_type  <= t;
        vert_a    <= IDX_W'(a);
        vert_b    <= IDX_W'(b);
        vert_c    <= IDX_W'(c);
        pos_x     <= x;
        pos_y     <= y;
        pos_z     <= z;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predict(t, a, b, c, x, y, z);
    endtask

    task automatic put_vertex(int a, logic signed [15:0] x, logic signed [15:0] y,
                              logic signed [15:0] z);
        send_request(REQ_WRITE, a, $urandom_range(0, 1023), $urandom_range(0, 1023), x, y, z);
    endtask

    task automatic add_triangle(int a, int b, int c);
        send_request(REQ_TRI, a, b, c, 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic read_normal(int a);
        send_request(REQ_READ, a, $urandom_range(0, 1023), $urandom_range(0, 1023),
                     16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic drain;
        while (pending_normals.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        normal_t want;
        if (rsp_valid && !rsp_stall)
        begin
            if (pending_normals.size() == 0)
            begin
                $display("%0t unexpected result %h %h %h %b", $time,
                         norm_x, norm_y, norm_z, zero_normal);
                errors++;
            end
            else
            begin
                want = pending_normals.pop_front();
                if (norm_x !== want.nx)
                begin
                    $display("%0t norm_x expected %0d actual %0d", $time, want.nx, norm_x);
                    errors++;
                end
                if (norm_y !== want.ny)
                begin
                    $display("%0t norm_y expected %0d actual %0d", $time, want.ny, norm_y);
                    errors++;
                end
                if (norm_z !== want.nz)
                begin
                    $display("%0t norm_z expected %0d actual %0d", $time, want.nz, norm_z);
                    errors++;
                end
                if (zero_normal !== want.zero)
                begin
                    $display("%0t zero_normal expected %b actual %b", $time,
                             want.zero, zero_normal);
                    errors++;
                end
            end
            rsp_hold = lazy ? $urandom_range(0, 15) : 0;
        end
        else if (rsp_hold > 0)
            rsp_hold--;
        rsp_stall <= (rsp_hold != 0);
    end

    // reads of vertices never touched see the cleared sums
    task automatic test_unwritten_reads;
        read_normal(0);
        read_normal(1023);
        read_normal(513);
    endtask

    task automatic test_directed;
        put_vertex(0, 16'sh7fff, 16'sh8000, 16'sh0000);
        put_vertex(1023, 16'sh8000, 16'sh7fff, 16'sh7fff);
        put_vertex(512, 16'sh8000, 16'sh8000, 16'sh8000);
        put_vertex(341, 16'sh0100, 16'sh0200, -16'sh0100);
        add_triangle(0, 1023, 512);
        add_triangle(512, 341, 0);
        read_normal(0);
        read_normal(1023);
        read_normal(341);
        // repeated corner adds zero
        add_triangle(341, 341, 0);
        read_normal(341);
        // collinear corners
        put_vertex(100, 16'sh0000, 16'sh0000, 16'sh0000);
        put_vertex(101, 16'sh0100, 16'sh0100, 16'sh0100);
        put_vertex(102, 16'sh0200, 16'sh0200, 16'sh0200);
        add_triangle(100, 101, 102);
        read_normal(101);
        send_request(REQ_SPARE, 0, 1023, 512, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        // rewrite clears the sum
        put_vertex(0, 16'sh0001, 16'sh0002, 16'sh0003);
        read_normal(0);
        read_normal(512);
    endtask

    function automatic logic signed [15:0] coord();
        case ($urandom_range(0, 5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'($urandom_range(0, 1023) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_random;
        int pool [16];
        int v [3];
        int pick;
        foreach (pool[i])
            pool[i] = $urandom_range(0, 1023);
        for (int n = 0; n < 1250; n++)
        begin
            if (n % 100 == 0)
                lazy = $urandom_range(0, 3) != 0;
            if (n % 200 == 0)
                pool[$urandom_range(0, 15)] = $urandom_range(0, 1023);
            pick = $urandom_range(0, 99);
            for (int k = 0; k < 3; k++)
                v[k] = pool[$urandom_range(0, 15)];
            if (pick < 20)
                put_vertex($urandom_range(0, 3) == 0 ? $urandom_range(0, 1023) : v[0],
                           coord(), coord(), coord());
            else if (pick < 62)
            begin
                for (int k = 0; k < 3; k++)
                    if (!placed[v[k]])
                        put_vertex(v[k], coord(), coord(), coord());
                add_triangle(v[0], v[1], v[2]);
            end
            else if (pick < 95)
                read_normal($urandom_range(0, 7) == 0 ? $urandom_range(0, 1023) : v[0]);
            else
                send_request(REQ_SPARE, $urandom_range(0, 1023), $urandom_range(0, 1023),
                             $urandom_range(0, 1023), 16'($urandom), 16'($urandom),
                             16'($urandom));
        end
    endtask

    initial
    begin
        for (int i = 0; i < VCOUNT; i++)
            for (int k = 0; k < 3; k++)
            begin
                normal_sum[i][k] = 0;
                mesh_pos[i][k] = '0;
            end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_unwritten_reads();
        test_directed();
        test_random();
        req_valid <= 1'b0;
        drain();
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

FILE: vertex_normal_accumulator.f
rtl/core/vna_pkg.sv
rtl/core/vna_front.sv
rtl/core/vna_norm.sv
rtl/core/vna_back.sv
rtl/core/vertex_normal_accumulator.sv
tb/sv/vertex_normal_accumulator_test.sv
